// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file of the scheduler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge and switched off in reset.
`define RRS_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition on one edge that must bring a consequence on the following edge.
`define RRS_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/rrs_pkg.sv -----
// Shared constants, types and helper functions of the response ratio scheduler.
package rrs_pkg;

    localparam int WAIT_DEPTH = 16;
    localparam int TIME_BITS  = 16;
    localparam int ID_BITS    = 8;

    localparam int IDX_W  = $clog2(WAIT_DEPTH);
    localparam int CNT_W  = $clog2(WAIT_DEPTH + 1);
    localparam int PROD_W = 2 * TIME_BITS;
    localparam int OP_W   = 2;
    localparam int EV_W   = 3;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(WAIT_DEPTH);
    localparam logic [CNT_W-1:0] ONE_COUNT  = CNT_W'(1);

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
    localparam logic [TIME_BITS-1:0] TIME_ONE = TIME_BITS'(1);

    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [EV_W-1:0] EV_NO_JOB   = 3'd0;
    localparam logic [EV_W-1:0] EV_NEW_JOB  = 3'd1;
    localparam logic [EV_W-1:0] EV_ANOTHER  = 3'd2;
    localparam logic [EV_W-1:0] EV_COMPLETE = 3'd3;
    localparam logic [EV_W-1:0] EV_RENEW    = 3'd4;
    localparam logic [EV_W-1:0] EV_ACCEPTED = 3'd5;
    localparam logic [EV_W-1:0] EV_FULL     = 3'd6;
    localparam logic [EV_W-1:0] EV_CLEARED  = 3'd7;

    typedef struct packed {
        logic [ID_BITS-1:0]   id;
        logic [TIME_BITS-1:0] need;
        logic [TIME_BITS-1:0] ticks;
    } wait_entry_t;

    localparam int ENTRY_W = $bits(wait_entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_MUL,
        ST_CMP,
        ST_PASS,
        ST_EMIT
    } state_t;

    function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] v);
        logic [TIME_BITS-1:0] r;
        if (v == TIME_MAX)
        begin
            r = v;
        end
        else
        begin
            r = v + TIME_ONE;
        end
        return r;
    endfunction

endpackage

// ----- rtl/rrs_ram.sv -----
// Generic single write port RAM with one registered read port.
module rrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/rrs_xcmp.sv -----
// Cross-multiply ratio comparator: registered products, then a compare.
module rrs_xcmp (
    input  logic                           clk,
    input  logic                           en,
    input  logic [rrs_pkg::TIME_BITS-1:0]  cand_ticks,
    input  logic [rrs_pkg::TIME_BITS-1:0]  cand_need,
    input  logic [rrs_pkg::TIME_BITS-1:0]  best_ticks,
    input  logic [rrs_pkg::TIME_BITS-1:0]  best_need,
    output logic                           gt
);

    logic [rrs_pkg::PROD_W-1:0] lhs_reg;
    logic [rrs_pkg::PROD_W-1:0] rhs_reg;

    // The candidate beats the best so far only on a strictly greater ratio,
    // so the earlier arrival keeps its place on a tie.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lhs_reg <= rrs_pkg::PROD_W'(cand_ticks) * rrs_pkg::PROD_W'(best_need);
            rhs_reg <= rrs_pkg::PROD_W'(best_ticks) * rrs_pkg::PROD_W'(cand_need);
        end
    end

    assign gt = lhs_reg > rhs_reg;

endmodule

// ----- rtl/response_ratio_job_scheduler.sv -----
// Non-preemptive highest response ratio next scheduler with a sixteen entry wait table in RAM.
// An add, a clear or an unused op passes from idle to the emit state, where its result is
// registered. A tick that only ages the table makes one pass over the n waiting jobs; a tick
// that loads a job first scans the table: the scan passes each further entry through the
// single cross-multiply comparator in two steps (multiply, then compare), and one pass over the
// single RAM port then closes the gap left by the chosen job and ages every remaining entry, one
// entry a cycle. The block takes one transaction at a time and holds job_stall high until its
// result has moved into the output register, which frees the input side while the result waits
// to be taken.
module response_ratio_job_scheduler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_valid,
    output logic                          job_stall,
    input  logic [rrs_pkg::OP_W-1:0]      op,
    input  logic [rrs_pkg::ID_BITS-1:0]   job_id,
    input  logic [rrs_pkg::TIME_BITS-1:0] job_need,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [rrs_pkg::EV_W-1:0]      event_res,
    output logic                          running_valid,
    output logic [rrs_pkg::ID_BITS-1:0]   running_id,
    output logic [rrs_pkg::TIME_BITS-1:0] executed_ticks,
    output logic                          finished_valid,
    output logic [rrs_pkg::ID_BITS-1:0]   finished_id,
    output logic [rrs_pkg::CNT_W-1:0]     waiting_count
);

    rrs_pkg::state_t state_reg;
    rrs_pkg::state_t state_next;

    logic [rrs_pkg::CNT_W-1:0]     count_reg;
    logic [rrs_pkg::CNT_W-1:0]     count_next;
    logic                          run_valid_reg;
    logic                          run_valid_next;
    logic [rrs_pkg::ID_BITS-1:0]   run_id_reg;
    logic [rrs_pkg::ID_BITS-1:0]   run_id_next;
    logic [rrs_pkg::TIME_BITS-1:0] run_need_reg;
    logic [rrs_pkg::TIME_BITS-1:0] run_need_next;
    logic [rrs_pkg::TIME_BITS-1:0] run_exec_reg;
    logic [rrs_pkg::TIME_BITS-1:0] run_exec_next;
    logic [rrs_pkg::CNT_W-1:0]     idx_reg;
    logic [rrs_pkg::CNT_W-1:0]     idx_next;
    logic                          remove_reg;
    logic                          remove_next;
    logic                          res_valid_reg;
    logic                          res_valid_next;

    rrs_pkg::wait_entry_t          best_reg;
    rrs_pkg::wait_entry_t          best_next;
    logic [rrs_pkg::IDX_W-1:0]     best_idx_reg;
    logic [rrs_pkg::IDX_W-1:0]     best_idx_next;
    logic [rrs_pkg::EV_W-1:0]      ev_reg;
    logic [rrs_pkg::EV_W-1:0]      ev_next;
    logic                          fin_valid_reg;
    logic                          fin_valid_next;
    logic [rrs_pkg::ID_BITS-1:0]   fin_id_reg;
    logic [rrs_pkg::ID_BITS-1:0]   fin_id_next;

    logic [rrs_pkg::EV_W-1:0]      event_res_reg;
    logic                          running_valid_reg;
    logic [rrs_pkg::ID_BITS-1:0]   running_id_reg;
    logic [rrs_pkg::TIME_BITS-1:0] executed_ticks_reg;
    logic                          finished_valid_reg;
    logic [rrs_pkg::ID_BITS-1:0]   finished_id_reg;
    logic [rrs_pkg::CNT_W-1:0]     waiting_count_reg;

    logic                          accept;
    logic                          out_load;
    logic                          last_idx;
    logic                          take_best;
    logic                          run_done;
    logic                          tick_load;
    logic                          scan_done;
    logic [rrs_pkg::TIME_BITS-1:0] exec_inc;
    logic [rrs_pkg::TIME_BITS-1:0] need_fix;
    logic [rrs_pkg::CNT_W-1:0]     src_idx;

    logic                          ram_we;
    logic [rrs_pkg::IDX_W-1:0]     ram_waddr;
    rrs_pkg::wait_entry_t          ram_wdata;
    logic [rrs_pkg::IDX_W-1:0]     ram_raddr;
    logic [rrs_pkg::ENTRY_W-1:0]   ram_rdata;
    rrs_pkg::wait_entry_t          rd_entry;
    logic                          xcmp_en;
    logic                          cand_gt;

    rrs_ram #(
        .WIDTH (rrs_pkg::ENTRY_W),
        .DEPTH (rrs_pkg::WAIT_DEPTH)
    ) u_wait_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rrs_xcmp u_xcmp (
        .clk        (clk),
        .en         (xcmp_en),
        .cand_ticks (rd_entry.ticks),
        .cand_need  (rd_entry.need),
        .best_ticks (best_reg.ticks),
        .best_need  (best_reg.need),
        .gt         (cand_gt)
    );

    assign rd_entry  = rrs_pkg::wait_entry_t'(ram_rdata);
    assign job_stall = (state_reg != rrs_pkg::ST_IDLE);
    assign accept    = job_valid && (state_reg == rrs_pkg::ST_IDLE);
    assign out_load  = (state_reg == rrs_pkg::ST_EMIT) && (!res_valid_reg || !res_stall);
    assign last_idx  = ((idx_reg + rrs_pkg::ONE_COUNT) == count_reg);
    assign take_best = (state_reg == rrs_pkg::ST_CMP) && cand_gt;
    assign exec_inc  = rrs_pkg::sat_inc(run_exec_reg);
    assign run_done  = run_valid_reg && (exec_inc >= run_need_reg);
    assign tick_load = (!run_valid_reg || run_done) && (count_reg != '0);
    assign need_fix  = (job_need == '0) ? rrs_pkg::TIME_ONE : job_need;
    assign scan_done = ((state_reg == rrs_pkg::ST_FIRST) && (count_reg == rrs_pkg::ONE_COUNT))
                    || ((state_reg == rrs_pkg::ST_CMP) && last_idx);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rrs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if ((op == rrs_pkg::OP_TICK) && tick_load)
                    begin
                        state_next = rrs_pkg::ST_FIRST;
                    end
                    else if ((op == rrs_pkg::OP_TICK) && (count_reg != '0))
                    begin
                        state_next = rrs_pkg::ST_PASS;
                    end
                    else
                    begin
                        state_next = rrs_pkg::ST_EMIT;
                    end
                end
            end
            rrs_pkg::ST_FIRST:
            begin
                if (count_reg == rrs_pkg::ONE_COUNT)
                begin
                    state_next = rrs_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = rrs_pkg::ST_MUL;
                end
            end
            rrs_pkg::ST_MUL:
            begin
                state_next = rrs_pkg::ST_CMP;
            end
            rrs_pkg::ST_CMP:
            begin
                if (last_idx)
                begin
                    state_next = rrs_pkg::ST_PASS;
                end
                else
                begin
                    state_next = rrs_pkg::ST_MUL;
                end
            end
            rrs_pkg::ST_PASS:
            begin
                if (last_idx)
                begin
                    state_next = rrs_pkg::ST_EMIT;
                end
            end
            rrs_pkg::ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = rrs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rrs_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        count_next     = count_reg;
        run_valid_next = run_valid_reg;
        run_id_next    = run_id_reg;
        run_need_next  = run_need_reg;
        run_exec_next  = run_exec_reg;
        idx_next       = idx_reg;
        remove_next    = remove_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        ev_next        = ev_reg;
        fin_valid_next = fin_valid_reg;
        fin_id_next    = fin_id_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg[rrs_pkg::IDX_W-1:0];
        ram_wdata      = '{id: rd_entry.id, need: rd_entry.need,
                           ticks: rrs_pkg::sat_inc(rd_entry.ticks)};
        xcmp_en        = 1'b0;

        case (state_reg)
            rrs_pkg::ST_IDLE:
            begin
                idx_next = '0;
                if (accept)
                begin
                    fin_valid_next = 1'b0;
                    fin_id_next    = '0;
                    remove_next    = 1'b0;
                    case (op)
                        rrs_pkg::OP_ADD:
                        begin
                            if (count_reg == rrs_pkg::FULL_COUNT)
                            begin
                                ev_next = rrs_pkg::EV_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[rrs_pkg::IDX_W-1:0];
                                ram_wdata  = '{id: job_id, need: need_fix, ticks: '0};
                                count_next = count_reg + rrs_pkg::ONE_COUNT;
                                ev_next    = rrs_pkg::EV_ACCEPTED;
                            end
                        end
                        rrs_pkg::OP_TICK:
                        begin
                            if (run_valid_reg)
                            begin
                                if (run_done)
                                begin
                                    fin_valid_next = 1'b1;
                                    fin_id_next    = run_id_reg;
                                    run_valid_next = 1'b0;
                                    run_id_next    = '0;
                                    run_need_next  = '0;
                                    run_exec_next  = '0;
                                    ev_next = (count_reg != '0) ? rrs_pkg::EV_ANOTHER
                                                                : rrs_pkg::EV_COMPLETE;
                                end
                                else
                                begin
                                    run_exec_next = exec_inc;
                                    ev_next       = rrs_pkg::EV_RENEW;
                                end
                            end
                            else
                            begin
                                ev_next = (count_reg != '0) ? rrs_pkg::EV_NEW_JOB
                                                            : rrs_pkg::EV_NO_JOB;
                            end
                        end
                        rrs_pkg::OP_CLEAR:
                        begin
                            count_next     = '0;
                            run_valid_next = 1'b0;
                            run_id_next    = '0;
                            run_need_next  = '0;
                            run_exec_next  = '0;
                            ev_next        = rrs_pkg::EV_CLEARED;
                        end
                        default:
                        begin
                            ev_next = rrs_pkg::EV_NO_JOB;
                        end
                    endcase
                end
            end
            rrs_pkg::ST_FIRST:
            begin
                best_next     = rd_entry;
                best_idx_next = '0;
                idx_next      = rrs_pkg::ONE_COUNT;
            end
            rrs_pkg::ST_MUL:
            begin
                xcmp_en = 1'b1;
            end
            rrs_pkg::ST_CMP:
            begin
                if (take_best)
                begin
                    best_next     = rd_entry;
                    best_idx_next = idx_reg[rrs_pkg::IDX_W-1:0];
                end
                idx_next = idx_reg + rrs_pkg::ONE_COUNT;
            end
            rrs_pkg::ST_PASS:
            begin
                ram_we   = 1'b1;
                idx_next = idx_reg + rrs_pkg::ONE_COUNT;
            end
            rrs_pkg::ST_EMIT:
            begin
                idx_next = '0;
            end
            default:
            begin
                idx_next = '0;
            end
        endcase

        // The chosen job leaves the table; the pass then closes the gap behind it.
        if (scan_done)
        begin
            run_valid_next = 1'b1;
            run_id_next    = best_next.id;
            run_need_next  = best_next.need;
            run_exec_next  = '0;
            count_next     = count_reg - rrs_pkg::ONE_COUNT;
            remove_next    = 1'b1;
            idx_next       = '0;
        end
    end

    // The read address is that of the entry needed in the next cycle, so the registered read
    // data holds the indexed entry, or, in the pass beyond a removed entry, the one above it.
    always_comb
    begin
        if (remove_next && (idx_next >= rrs_pkg::CNT_W'(best_idx_next)))
        begin
            src_idx = idx_next + rrs_pkg::ONE_COUNT;
        end
        else
        begin
            src_idx = idx_next;
        end
        if (state_next == rrs_pkg::ST_PASS)
        begin
            ram_raddr = src_idx[rrs_pkg::IDX_W-1:0];
        end
        else
        begin
            ram_raddr = idx_next[rrs_pkg::IDX_W-1:0];
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (out_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rrs_pkg::ST_IDLE;
            count_reg     <= '0;
            run_valid_reg <= 1'b0;
            run_id_reg    <= '0;
            run_need_reg  <= '0;
            run_exec_reg  <= '0;
            idx_reg       <= '0;
            remove_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            run_valid_reg <= run_valid_next;
            run_id_reg    <= run_id_next;
            run_need_reg  <= run_need_next;
            run_exec_reg  <= run_exec_next;
            idx_reg       <= idx_next;
            remove_reg    <= remove_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg      <= best_next;
        best_idx_reg  <= best_idx_next;
        ev_reg        <= ev_next;
        fin_valid_reg <= fin_valid_next;
        fin_id_reg    <= fin_id_next;
        if (out_load)
        begin
            event_res_reg      <= ev_reg;
            running_valid_reg  <= run_valid_reg;
            running_id_reg     <= run_valid_reg ? run_id_reg : '0;
            executed_ticks_reg <= run_valid_reg ? run_exec_reg : '0;
            finished_valid_reg <= fin_valid_reg;
            finished_id_reg    <= fin_id_reg;
            waiting_count_reg  <= count_reg;
        end
    end

    assign res_valid      = res_valid_reg;
    assign event_res      = event_res_reg;
    assign running_valid  = running_valid_reg;
    assign running_id     = running_id_reg;
    assign executed_ticks = executed_ticks_reg;
    assign finished_valid = finished_valid_reg;
    assign finished_id    = finished_id_reg;
    assign waiting_count  = waiting_count_reg;

endmodule

// ----- rtl/rrs_checker.sv -----
// Port level checker for the response ratio scheduler, bound to the top level.
`include "assert_macros.svh"

module rrs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          job_valid,
    input logic                          job_stall,
    input logic [rrs_pkg::OP_W-1:0]      op,
    input logic [rrs_pkg::ID_BITS-1:0]   job_id,
    input logic [rrs_pkg::TIME_BITS-1:0] job_need,
    input logic                          res_valid,
    input logic                          res_stall,
    input logic [rrs_pkg::EV_W-1:0]      event_res,
    input logic                          running_valid,
    input logic [rrs_pkg::ID_BITS-1:0]   running_id,
    input logic [rrs_pkg::TIME_BITS-1:0] executed_ticks,
    input logic                          finished_valid,
    input logic [rrs_pkg::ID_BITS-1:0]   finished_id,
    input logic [rrs_pkg::CNT_W-1:0]     waiting_count
);

    // The block stays busy after it accepts a transaction, so no second one follows straight behind.
    `RRS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, job_valid && !job_stall, job_stall, "scheduler took a second transaction straight after the first")

    `RRS_ASSERT_NEXT(a_result_held, clk, rst_n, res_valid && res_stall, res_valid && $stable(event_res) && $stable(waiting_count) && $stable(finished_id), "stalled result changed")

    `RRS_ASSERT(a_idle_run_zero, clk, rst_n, res_valid && !running_valid |-> running_id == '0 && executed_ticks == '0, "run fields not zero with no job running")

    `RRS_ASSERT(a_count_range, clk, rst_n, res_valid |-> waiting_count <= rrs_pkg::WAIT_DEPTH, "wait table count beyond its depth")

    `RRS_ASSERT(a_finish_event, clk, rst_n, res_valid && finished_valid |-> (event_res == rrs_pkg::EV_COMPLETE || event_res == rrs_pkg::EV_ANOTHER), "finished job reported with a wrong event")

endmodule

bind response_ratio_job_scheduler rrs_checker u_rrs_checker (.*);
